[src/segrect_pkg.sv]
// Shared types, widths and helper functions for the segment/rectangle collision block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package segrect_pkg;

  // Table size and coordinate width
  localparam int MAX_RECTS  = 16;
  localparam int COORD_BITS = 12;

  // Fixed field widths
  localparam int IDX_W      = 4;
  localparam int RCOUNT_W   = 5;
  localparam int TOL_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Derived arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int VAL_W  = PROD_W + 1;
  localparam int NUM_W  = $clog2(MAX_RECTS + 1);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_INSIDE = 2'd1,
    CAUSE_EDGE   = 2'd2
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_COUNT = 1'b0,
    CFG_TOLERANCE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ORI_COLLINEAR = 2'd0,
    ORI_POS       = 2'd1,
    ORI_NEG       = 2'd2
  } orient_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Input word
  typedef struct packed {
    op_t                   operation;
    logic [IDX_W-1:0]      entry_index;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } req_t;

  // Result word
  typedef struct packed {
    logic   collides;
    cause_t cause;
  } rsp_t;

  // One rectangle table entry
  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] bottom;
    logic [COORD_BITS-1:0] top;
  } rect_t;

  // Segment under test
  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
  } seg_t;

  // Entry handed from the ring head to the checker
  typedef struct packed {
    logic  valid;
    logic  last;
    rect_t rect;
  } chk_feed_t;

  // Checker status back to the control
  typedef struct packed {
    logic done;
    logic in_box;
    logic crossed;
  } chk_stat_t;

  // Signed difference of two unsigned coordinates
  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] r;
    r = $signed({1'b0, a}) - $signed({1'b0, b});
    return r;
  endfunction

  // Orientation class of a cross product against the collinear tolerance
  function automatic orient_t orient_of(input logic signed [VAL_W-1:0] v,
                                        input logic [TOL_W-1:0] tol);
    logic [VAL_W-1:0] mag;
    orient_t          o;
    mag = v[VAL_W-1] ? unsigned'(-v) : unsigned'(v);
    if (mag < VAL_W'(tol)) begin
      o = ORI_COLLINEAR;
    end else if (!v[VAL_W-1] && (v != '0)) begin
      o = ORI_POS;
    end else begin
      o = ORI_NEG;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[src/segrect_cell.sv]
// One cell of the rectangle ring: holds a table entry, takes a load or the neighbor's entry.
// Depends on segrect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module segrect_cell (
  input  logic               clk,
  input  logic               load,
  input  segrect_pkg::rect_t load_rect,
  input  logic               shift,
  input  segrect_pkg::rect_t shift_rect,
  output segrect_pkg::rect_t rect
);
  import segrect_pkg::*;

  rect_t rect_next;

  // Load has precedence; loads only happen while the ring is at rest
  always_comb begin
    rect_next = rect;
    if (load) begin
      rect_next = load_rect;
    end else if (shift) begin
      rect_next = shift_rect;
    end
  end

  always_ff @(posedge clk) begin
    rect <= rect_next;
  end

endmodule

`default_nettype wire

[src/segrect_check.sv]
// Three-stage collision checker: products, orientation classes, crossing/inside accumulate.
// Depends on segrect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module segrect_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  segrect_pkg::seg_t                    seg,
  input  logic [segrect_pkg::TOL_W-1:0]        tol,
  input  segrect_pkg::chk_feed_t               feed,
  output segrect_pkg::chk_stat_t               stat
);
  import segrect_pkg::*;

  // Stage 1 operands
  logic signed [DIFF_W-1:0] dx, dy, h, w;
  logic signed [DIFF_W-1:0] d_l_ex, d_r_ex, d_b_ey, d_t_ey;
  logic signed [DIFF_W-1:0] d_sx_l, d_ex_l, d_sx_r, d_ex_r;
  logic signed [DIFF_W-1:0] d_t_sy, d_t_ey2, d_b_sy, d_b_ey2;
  logic                     inside_c;

  // Stage 1 registers
  logic                     s1_valid, s1_last, s1_inside;
  logic signed [PROD_W-1:0] p_ml, p_mr, p_nb, p_nt;
  logic signed [PROD_W-1:0] p_ba_s, p_ba_e, p_ad_s, p_ad_e;
  logic signed [PROD_W-1:0] p_bc_s, p_bc_e, p_cd_s, p_cd_e;

  // Stage 2 registers
  logic    s2_valid, s2_last, s2_inside;
  orient_t o_ba_s, o_ba_e, o_ad_s, o_ad_e, o_bc_s, o_bc_e, o_cd_s, o_cd_e;
  orient_t o_a, o_b, o_c, o_d;

  // Stage 3
  logic cross_c;
  logic acc_inside, acc_crossed, done;

  // Differences feeding the multipliers
  always_comb begin
    dx       = sdiff(seg.ex, seg.sx);
    dy       = sdiff(seg.ey, seg.sy);
    h        = sdiff(feed.rect.top, feed.rect.bottom);
    w        = sdiff(feed.rect.right, feed.rect.left);
    d_l_ex   = sdiff(feed.rect.left, seg.ex);
    d_r_ex   = sdiff(feed.rect.right, seg.ex);
    d_b_ey   = sdiff(feed.rect.bottom, seg.ey);
    d_t_ey   = sdiff(feed.rect.top, seg.ey);
    d_sx_l   = sdiff(seg.sx, feed.rect.left);
    d_ex_l   = sdiff(seg.ex, feed.rect.left);
    d_sx_r   = sdiff(seg.sx, feed.rect.right);
    d_ex_r   = sdiff(seg.ex, feed.rect.right);
    d_t_sy   = sdiff(feed.rect.top, seg.sy);
    d_t_ey2  = sdiff(feed.rect.top, seg.ey);
    d_b_sy   = sdiff(feed.rect.bottom, seg.sy);
    d_b_ey2  = sdiff(feed.rect.bottom, seg.ey);
    inside_c = (seg.ex >= feed.rect.left) && (seg.ex <= feed.rect.right) &&
               (seg.ey >= feed.rect.bottom) && (seg.ey <= feed.rect.top);
  end

  // Stage 1: flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= feed.valid;
      s1_last  <= feed.last;
    end
  end

  // Stage 1: products. Segment side uses dy*(x-ex) and dx*(y-ey) per bound;
  // edge side uses height or width times the point offset from the edge.
  always_ff @(posedge clk) begin
    s1_inside <= inside_c;
    p_ml      <= dy * d_l_ex;
    p_mr      <= dy * d_r_ex;
    p_nb      <= dx * d_b_ey;
    p_nt      <= dx * d_t_ey;
    p_ba_s    <= h * d_sx_l;
    p_ba_e    <= h * d_ex_l;
    p_cd_s    <= h * d_sx_r;
    p_cd_e    <= h * d_ex_r;
    p_ad_s    <= w * d_t_sy;
    p_ad_e    <= w * d_t_ey2;
    p_bc_s    <= w * d_b_sy;
    p_bc_e    <= w * d_b_ey2;
  end

  // Stage 2: flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
  end

  // Stage 2: orientation classes of all twelve cross products
  always_ff @(posedge clk) begin
    s2_inside <= s1_inside;
    o_ba_s    <= orient_of(VAL_W'(p_ba_s), tol);
    o_ba_e    <= orient_of(VAL_W'(p_ba_e), tol);
    o_ad_s    <= orient_of(VAL_W'(p_ad_s), tol);
    o_ad_e    <= orient_of(VAL_W'(p_ad_e), tol);
    o_bc_s    <= orient_of(VAL_W'(p_bc_s), tol);
    o_bc_e    <= orient_of(VAL_W'(p_bc_e), tol);
    o_cd_s    <= orient_of(VAL_W'(p_cd_s), tol);
    o_cd_e    <= orient_of(VAL_W'(p_cd_e), tol);
    o_a       <= orient_of(VAL_W'(p_ml) - VAL_W'(p_nt), tol);
    o_b       <= orient_of(VAL_W'(p_ml) - VAL_W'(p_nb), tol);
    o_c       <= orient_of(VAL_W'(p_mr) - VAL_W'(p_nb), tol);
    o_d       <= orient_of(VAL_W'(p_mr) - VAL_W'(p_nt), tol);
  end

  // Last stage: the left, top, bottom or right edge crossed
  always_comb begin
    cross_c = ((o_ba_s != o_ba_e) && (o_b != o_a)) ||
              ((o_ad_s != o_ad_e) && (o_a != o_d)) ||
              ((o_bc_s != o_bc_e) && (o_b != o_c)) ||
              ((o_cd_s != o_cd_e) && (o_c != o_d));
  end

  // Accumulate over the entries of one query
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_inside  <= 1'b0;
      acc_crossed <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= s2_last;
      if (clear) begin
        acc_inside  <= 1'b0;
        acc_crossed <= 1'b0;
      end else if (s2_valid) begin
        acc_inside  <= acc_inside | s2_inside;
        acc_crossed <= acc_crossed | cross_c;
      end
    end
  end

  assign stat = '{done: done, in_box: acc_inside, crossed: acc_crossed};

endmodule

`default_nettype wire

[src/segment_rectangle_collision.sv]
// Top level: rectangle ring of cells, query control, config registers, result register.
// Depends on segrect_pkg, segrect_cell and segrect_check.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): a load word writes one rectangle
//   entry and produces no result; a query word checks a segment against the
//   first min(rect_count, MAX_RECTS) entries and produces one result word on the rsp channel.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes rect_count or
//   collinear_tolerance; always ready, to be used only while the block is idle.
//   A load word leaves the block idle and ready for the next word. A query
//   rotates the ring of MAX_RECTS cells past the checker, one entry per cycle,
//   then drains a three-stage checker: the result is loaded into the output
//   register and req_ready returns in the same cycle. The ring always makes a
//   full turn, whatever rect_count is.
//   The result sits in an output register; a new word is accepted while it
//   waits. If the receiver stalls, a following query finishes its scan and
//   holds its result until the previous one is taken.
//   Reset clears the control, sets rect_count to 0 and collinear_tolerance to
//   1; rectangle entries hold no defined value until loaded.
`timescale 1ns / 1ps
`default_nettype none

module segment_rectangle_collision (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  segrect_pkg::req_t                      req_data,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output segrect_pkg::rsp_t                      rsp_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [segrect_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [segrect_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import segrect_pkg::*;

  localparam logic [NUM_W-1:0] LAST_CNT = NUM_W'(MAX_RECTS - 1);

  state_t               state, state_next;
  logic [NUM_W-1:0]     cnt, n_active;
  logic [RCOUNT_W-1:0]  rect_count;
  logic [TOL_W-1:0]     tolerance;
  seg_t                 seg;
  rect_t                load_rect;
  rect_t                ring [MAX_RECTS];
  logic [MAX_RECTS-1:0] load_hit;
  logic                 req_fire, load_fire, query_fire, scan, rsp_load;
  chk_feed_t            feed;
  chk_stat_t            stat;

  assign cfg_ready  = 1'b1;
  assign req_fire   = req_valid && req_ready;
  assign load_fire  = req_fire && (req_data.operation == OP_LOAD);
  assign query_fire = req_fire && (req_data.operation == OP_QUERY);
  assign load_rect  = '{left: req_data.rect_left, right: req_data.rect_right,
                        bottom: req_data.rect_bottom, top: req_data.rect_top};

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count <= '0;
      tolerance  <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RECT_COUNT: rect_count <= cfg_data[RCOUNT_W-1:0];
        CFG_TOLERANCE:  tolerance  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring of cells; cell 0 is the head read by the checker
  for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
    assign load_hit[k] = load_fire && (int'(req_data.entry_index) == k);
    segrect_cell u_cell (
      .clk        (clk),
      .load       (load_hit[k]),
      .load_rect  (load_rect),
      .shift      (scan),
      .shift_rect (ring[(k + 1) % MAX_RECTS]),
      .rect       (ring[k])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (query_fire) state_next = ST_SCAN;
      ST_SCAN:  if (cnt == LAST_CNT) state_next = ST_DRAIN;
      ST_DRAIN: if (stat.done) state_next = ST_DONE;
      ST_DONE:  if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_ready = 1'b0;
    scan      = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_SCAN: scan      = 1'b1;
      ST_DONE: rsp_load  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (query_fire) begin
        cnt <= '0;
      end else if (scan) begin
        cnt <= cnt + NUM_W'(1);
      end
    end
  end

  // Query operands
  always_ff @(posedge clk) begin
    if (query_fire) begin
      seg      <= '{sx: req_data.start_x, sy: req_data.start_y,
                    ex: req_data.end_x, ey: req_data.end_y};
      n_active <= (int'(rect_count) > MAX_RECTS) ? NUM_W'(MAX_RECTS) : NUM_W'(rect_count);
    end
  end

  assign feed = '{valid: scan && (cnt < n_active), last: scan && (cnt == LAST_CNT),
                  rect: ring[0]};

  segrect_check u_check (
    .clk   (clk),
    .rst   (rst),
    .clear (query_fire),
    .seg   (seg),
    .tol   (tolerance),
    .feed  (feed),
    .stat  (stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data.collides <= stat.in_box || stat.crossed;
      rsp_data.cause    <= stat.in_box ? CAUSE_INSIDE :
                           (stat.crossed ? CAUSE_EDGE : CAUSE_NONE);
    end
  end

`ifndef SYNTHESIS
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    query_fire |=> !req_ready)
    else $error("word accepted while a query is in flight");

  a_full_turn: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == LAST_CNT) |=> (state == ST_DRAIN))
    else $error("ring scan did not end after a full turn");

  a_cause_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.collides == (rsp_data.cause != CAUSE_NONE)))
    else $error("collides and cause disagree");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule

`default_nettype wire

[sim/segment_rectangle_collision_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for segment_rectangle_collision: obstacle loads, segment queries
// and register writes, checked against a built-in predictor. Depends on segrect_pkg and segment_rectangle_collision.

module segment_rectangle_collision_tb;
  import segrect_pkg::*;

  localparam int CMAX = (1 << COORD_BITS) - 1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req_data  = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  segment_rectangle_collision dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  // Predictor state: obstacle table and register copies as seen at the port
  rect_t               obstacle_tbl [MAX_RECTS];
  logic [RCOUNT_W-1:0] count_reg = RCOUNT_W'(0);
  logic [TOL_W-1:0]    tol_reg   = TOL_W'(1);

  rsp_t verdict_q [$];  // expected verdicts, oldest first
  req_t pending_q [$];  // words waiting for the driver
  rsp_t want;
  int   idle_pct  = 23;
  int   err_count = 0;

  // Generator's view of the table, for aiming segments at real obstacles
  rect_t plan_tbl [MAX_RECTS];
  int    plan_n = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Orientation of r relative to the directed line p-q
  function automatic orient_t orient_cls(input longint px, py, qx, qy, rx, ry);
    longint v;
    longint mag;
    longint tl;
    v   = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    mag = (v < 0) ? -v : v;
    tl  = tol_reg;
    if (mag < tl) return ORI_COLLINEAR;
    if (v > 0) return ORI_POS;
    return ORI_NEG;
  endfunction

  function automatic bit edge_cut(input longint ax, ay, bx, by, sx, sy, ex, ey);
    orient_t o1, o2, o3, o4;
    o1 = orient_cls(ax, ay, bx, by, sx, sy);
    o2 = orient_cls(ax, ay, bx, by, ex, ey);
    o3 = orient_cls(sx, sy, ex, ey, ax, ay);
    o4 = orient_cls(sx, sy, ex, ey, bx, by);
    return (o1 != o2) && (o3 != o4);
  endfunction

  // Edges left, top, bottom, right; bounds used as given even when inverted
  function automatic bit rect_cut(input rect_t r, input longint sx, sy, ex, ey);
    longint l, rt, b, t;
    l  = r.left;
    rt = r.right;
    b  = r.bottom;
    t  = r.top;
    return edge_cut(l, b, l, t, sx, sy, ex, ey) || edge_cut(l, t, rt, t, sx, sy, ex, ey) ||
           edge_cut(l, b, rt, b, sx, sy, ex, ey) || edge_cut(rt, b, rt, t, sx, sy, ex, ey);
  endfunction

  // Verdict for one query against the active entries; end point inside wins
  function automatic rsp_t judge_segment(input req_t w);
    rsp_t v;
    int   n;
    int   i;
    bit   in_box;
    bit   crossed;
    n       = (count_reg > MAX_RECTS) ? MAX_RECTS : int'(count_reg);
    in_box  = 1'b0;
    crossed = 1'b0;
    for (i = 0; i < n; i++) begin
      if (w.end_x >= obstacle_tbl[i].left && w.end_x <= obstacle_tbl[i].right &&
          w.end_y >= obstacle_tbl[i].bottom && w.end_y <= obstacle_tbl[i].top)
        in_box = 1'b1;
    end
    if (!in_box) begin
      for (i = 0; i < n; i++) begin
        if (rect_cut(obstacle_tbl[i], w.start_x, w.start_y, w.end_x, w.end_y))
          crossed = 1'b1;
      end
    end
    v.collides = in_box || crossed;
    v.cause    = in_box ? CAUSE_INSIDE : (crossed ? CAUSE_EDGE : CAUSE_NONE);
    return v;
  endfunction

  function automatic void take_word(input req_t w);
    if (w.operation == OP_LOAD) begin
      obstacle_tbl[w.entry_index] = {w.rect_left, w.rect_right, w.rect_bottom, w.rect_top};
    end else begin
      verdict_q.push_back(judge_segment(w));
    end
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        take_word(req_data);
      end
      if (!req_valid || req_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_data  <= pending_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with no query outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (rsp_data.collides !== want.collides)
            report_mismatch($sformatf("collides got %0b want %0b",
                                      rsp_data.collides, want.collides));
          if (rsp_data.cause !== want.cause)
            report_mismatch($sformatf("cause got %0d want %0d",
                                      rsp_data.cause, want.cause));
        end
      end
      rsp_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Stimulus helpers
  function automatic logic [COORD_BITS-1:0] clamp_c(input int v);
    if (v < 0) return '0;
    if (v > CMAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int jitter(input int s);
    return int'($urandom_range(2 * s)) - s;
  endfunction

  function automatic req_t noise_word();
    logic [127:0] rnd;
    rnd = {$urandom(), $urandom(), $urandom(), $urandom()};
    return req_t'(rnd[$bits(req_t)-1:0]);
  endfunction

  task automatic push_load(input int idx, input int l, input int r, input int b, input int t);
    req_t w;
    w             = noise_word();
    w.operation   = OP_LOAD;
    w.entry_index = idx[IDX_W-1:0];
    w.rect_left   = clamp_c(l);
    w.rect_right  = clamp_c(r);
    w.rect_bottom = clamp_c(b);
    w.rect_top    = clamp_c(t);
    plan_tbl[idx] = {w.rect_left, w.rect_right, w.rect_bottom, w.rect_top};
    pending_q.push_back(w);
  endtask

  task automatic push_query(input int sx, input int sy, input int ex, input int ey);
    req_t w;
    w           = noise_word();
    w.operation = OP_QUERY;
    w.start_x   = clamp_c(sx);
    w.start_y   = clamp_c(sy);
    w.end_x     = clamp_c(ex);
    w.end_y     = clamp_c(ey);
    pending_q.push_back(w);
  endtask

  // Mostly ordinary boxes, some inverted, degenerate or fully random
  task automatic push_rand_load(input int idx);
    int l, r, b, t, k, tmp;
    l = $urandom_range(CMAX - 300);
    b = $urandom_range(CMAX - 300);
    r = l + $urandom_range(400);
    t = b + $urandom_range(400);
    k = $urandom_range(9);
    if (k == 7) begin
      if ($urandom_range(1)) begin
        tmp = l; l = r; r = tmp;
      end else begin
        tmp = b; b = t; t = tmp;
      end
    end else if (k == 8) begin
      l = $urandom_range(CMAX);
      r = $urandom_range(CMAX);
      b = $urandom_range(CMAX);
      t = $urandom_range(CMAX);
    end else if (k == 9) begin
      if ($urandom_range(1)) r = l;
      else t = b;
    end
    push_load(idx, l, r, b, t);
  endtask

  // Segments aimed at an active obstacle: inside, through, along an edge,
  // near a corner, starting on an edge; some fully random
  task automatic push_rand_query();
    int    j, k, lx, hx, ly, hy, cx, cy, sx, sy, ex, ey, y0, tmp;
    rect_t rc;
    j  = (plan_n > 0) ? $urandom_range(plan_n - 1) : $urandom_range(MAX_RECTS - 1);
    rc = plan_tbl[j];
    lx = (rc.left < rc.right) ? rc.left : rc.right;
    hx = (rc.left < rc.right) ? rc.right : rc.left;
    ly = (rc.bottom < rc.top) ? rc.bottom : rc.top;
    hy = (rc.bottom < rc.top) ? rc.top : rc.bottom;
    cx = (lx + hx) / 2;
    cy = (ly + hy) / 2;
    k  = $urandom_range(9);
    case (k)
      0, 1: begin
        sx = $urandom_range(CMAX);
        sy = $urandom_range(CMAX);
        ex = $urandom_range(CMAX);
        ey = $urandom_range(CMAX);
      end
      2, 3: begin
        ex = $urandom_range(lx, hx);
        ey = $urandom_range(ly, hy);
        sx = cx + jitter(600);
        sy = cy + jitter(600);
      end
      4, 5: begin
        if ($urandom_range(1)) begin
          sx = lx - int'($urandom_range(1, 300));
          ex = hx + int'($urandom_range(1, 300));
          sy = $urandom_range(ly, hy);
          ey = $urandom_range(ly, hy);
        end else begin
          sy = ly - int'($urandom_range(1, 300));
          ey = hy + int'($urandom_range(1, 300));
          sx = $urandom_range(lx, hx);
          ex = $urandom_range(lx, hx);
        end
        if ($urandom_range(1)) begin
          tmp = sx; sx = ex; ex = tmp;
          tmp = sy; sy = ey; ey = tmp;
        end
      end
      6: begin
        // nearly collinear with a horizontal edge, sensitive to the tolerance
        y0 = $urandom_range(1) ? int'(rc.top) : int'(rc.bottom);
        sx = lx - int'($urandom_range(500));
        ex = hx + int'($urandom_range(500));
        sy = y0 + jitter(2);
        ey = y0 + jitter(2);
      end
      7: begin
        ex = ($urandom_range(1) ? lx : hx) + jitter(3);
        ey = ($urandom_range(1) ? ly : hy) + jitter(3);
        sx = ex + jitter(400);
        sy = ey + jitter(400);
      end
      8: begin
        sx = $urandom_range(lx, hx);
        sy = rc.top;
        ex = sx + jitter(50);
        ey = int'(rc.top) + int'($urandom_range(1, 50));
      end
      default: begin
        sx = cx + jitter(hx - lx + 50);
        sy = cy + jitter(hy - ly + 50);
        ex = cx + jitter(hx - lx + 50);
        ey = cy + jitter(hy - ly + 50);
      end
    endcase
    push_query(sx, sy, ex, ey);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RECT_COUNT) begin
      count_reg = val[RCOUNT_W-1:0];
      plan_n    = (count_reg > MAX_RECTS) ? MAX_RECTS : int'(count_reg);
    end else begin
      tol_reg = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // Sender held back until every word is in and every verdict is out
  task automatic wait_idle();
    @(posedge clk);
    while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (MAX_RECTS + 8) @(posedge clk);
  endtask

  task automatic run_phase(input int cnt, input int tol, input int idle, input int items);
    int i;
    wait_idle();
    write_reg(CFG_RECT_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
    idle_pct = idle;
    for (i = 0; i < items; i++) begin
      if ($urandom_range(3) == 0) push_rand_load($urandom_range(MAX_RECTS - 1));
      else push_rand_query();
    end
  endtask

  initial begin
    int e;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // no active entries after reset
    push_query(0, 0, CMAX, CMAX);
    push_load(0, 100, 200, 100, 200);
    push_load(1, 0, CMAX, 4000, CMAX);
    push_load(2, 3000, 2000, 500, 600);  // inverted in x
    push_load(3, CMAX, CMAX, 0, 0);      // point box at the corner of the field
    wait_idle();
    write_reg(CFG_RECT_COUNT, CFG_DATA_W'(4));
    push_query(0, 0, 0, 0);
    push_query(50, 150, 150, 150);       // inside wins over the crossed edge
    push_query(50, 150, 250, 150);       // straight through
    push_query(300, 300, 100, 100);      // end on a corner, bounds inclusive
    push_query(2500, 0, 2500, 1000);     // through the inverted box
    push_query(CMAX, CMAX, 10, 10);
    push_query(300, 200, 400, 200);      // along the extension of an edge
    push_query(150, 200, 150, 300);      // starts on an edge
    push_query(CMAX, 100, CMAX, 0);      // ends on the point box

    // zero tolerance: a zero cross product is not collinear
    wait_idle();
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(0));
    push_query(150, 200, 150, 300);
    push_query(300, 200, 400, 200);
    push_query(0, 0, 0, 0);
    wait_idle();
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(255));
    push_query(150, 200, 150, 300);
    push_query(50, 150, 250, 150);

    // fill the rest of the table before any wider count is used
    for (e = 4; e < MAX_RECTS; e++) push_rand_load(e);

    run_phase(16, 1, 23, 90);
    run_phase(31, 1, 0, 60);   // count above table size, no idling
    run_phase(1, 0, 23, 60);
    run_phase(17, 255, 23, 60);
    run_phase(8, 3, 23, 60);
    run_phase(0, 2, 23, 30);
    run_phase(16, 0, 23, 60);
    run_phase(5, 128, 23, 40);
    wait_idle();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("FAILURE");
    $finish;
  end

endmodule
